@@ hdl/smac_pkg.sv @@
`default_nettype none
package smac_pkg;

   localparam int GRANULE_SHIFT = 3;
   localparam int CNT_W         = 14;

   typedef enum logic [1:0] {
      OP_CHECK  = 2'd0,
      OP_ACCESS = 2'd1,
      OP_DATA   = 2'd2,
      OP_HEAP   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      STS_OK     = 2'd0,
      STS_VIOL   = 2'd1,
      STS_EDGE   = 2'd2,
      STS_REJECT = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      REG_BASE  = 3'd0,
      REG_BYTES = 3'd1,
      REG_EN    = 3'd2,
      REG_DATA  = 3'd3,
      REG_HEAP  = 3'd4
   } reg_index_type;

   typedef enum logic [1:0] {
      CMD_STATUS = 2'd0,
      CMD_CHECK  = 2'd1,
      CMD_FILL   = 2'd2
   } cmd_kind_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHK_RD,
      ST_CHK_EV,
      ST_FILL,
      ST_ENDTAG,
      ST_DONE
   } state_type;

   typedef struct packed {
      cmd_kind_type     kind;
      status_type       status;
      logic [CNT_W-1:0] cnt;
      logic [2:0]       hi_off;
      logic [7:0]       tag;
      logic             end_en;
      logic [2:0]       end_tag;
   } cmd_type;

   typedef struct packed {
      logic [31:0] base;
      logic [15:0] bytes;
      logic        enable;
      logic [7:0]  data_tag;
      logic [7:0]  heap_tag;
   } cfg_type;

endpackage
`default_nettype wire

@@ hdl/shadow_memory_access_checker_core.sv @@
// Shadow-memory access checker with one signed tag byte per 8-byte granule.
// Input channel: req_opcode, req_addr and req_length are taken when req_push
// is high and req_full is low. Result channel: rsp_status is valid while
// rsp_empty is low and is consumed when rsp_pop is high.
// Configuration writes use csr_valid/csr_ready (always ready) with csr_index
// and csr_wdata; the user must make them only while the block is idle (not enforced).
// Items pass a front classifier into a two-entry command queue, so new
// items are taken while the back end still works on older ones.
// An item that needs no tag store work goes straight to the result stage. A
// check reads and then evaluates each granule touched on the single memory
// port; a tag fill writes one granule per cycle, length/8 granules, and one
// more end tag for a partial end.
// The back end takes the next item right after loading a result.
// After reset the block sweeps the tag store to zero, one entry per cycle,
// with req_full high; configuration writes still go.
// A stalled receiver holds the result register; the back end then waits and
// the queue fills up until req_full rises.
`default_nettype none
module shadow_memory_access_checker_core
   import smac_pkg::*;
#(
   parameter int SHADOW_ENTRIES = 4096,
   parameter int ADDR_BITS      = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [1:0]  req_opcode,
   input  wire logic [31:0] req_addr,
   input  wire logic [15:0] req_length,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [1:0]       rsp_status,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);

   localparam int IDX_W = $clog2(SHADOW_ENTRIES);

   cfg_type          cfg_ff, cfg_in;
   cmd_type          f_cmd, q_cmd;
   logic [IDX_W-1:0] f_idx, q_idx;
   logic             q_full, q_empty, q_pop, q_push, clearing;

   assign csr_ready = 1'b1;
   assign req_full  = clearing || q_full;
   assign q_push    = req_push && !req_full;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (reg_index_type'(csr_index))
            REG_BASE:  cfg_in.base     = csr_wdata;
            REG_BYTES: cfg_in.bytes    = csr_wdata[15:0];
            REG_EN:    cfg_in.enable   = csr_wdata[0];
            REG_DATA:  cfg_in.data_tag = csr_wdata[7:0];
            REG_HEAP:  cfg_in.heap_tag = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{base: 32'd0, bytes: 16'd0, enable: 1'b0,
                     data_tag: 8'hFF, heap_tag: 8'hFE};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   smac_front #(
      .SHADOW_ENTRIES(SHADOW_ENTRIES),
      .ADDR_BITS     (ADDR_BITS),
      .IDX_W         (IDX_W)
   ) u_front (
      .cfg      (cfg_ff),
      .opcode   (req_opcode),
      .addr     (req_addr),
      .length   (req_length),
      .cmd      (f_cmd),
      .first_idx(f_idx)
   );

   smac_queue #(
      .IDX_W(IDX_W)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .push_cmd(f_cmd),
      .push_idx(f_idx),
      .pop     (q_pop),
      .full    (q_full),
      .empty   (q_empty),
      .head_cmd(q_cmd),
      .head_idx(q_idx)
   );

   smac_back #(
      .SHADOW_ENTRIES(SHADOW_ENTRIES),
      .IDX_W         (IDX_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_cmd     (q_cmd),
      .q_idx     (q_idx),
      .q_pop     (q_pop),
      .clearing  (clearing),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_status(rsp_status)
   );

   // No item may enter while the tag store is being cleared.
   a_no_push_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !q_push)
      else $error("item accepted during tag store clear");

   // The back end never pops an empty queue.
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("command queue popped while empty");

   // A result never appears right after reset.
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("result present after reset");

endmodule
`default_nettype wire

@@ hdl/smac_front.sv @@
`default_nettype none
module smac_front
   import smac_pkg::*;
#(
   parameter int SHADOW_ENTRIES = 4096,
   parameter int ADDR_BITS      = 32,
   parameter int IDX_W          = 12
) (
   input  wire cfg_type          cfg,
   input  wire logic [1:0]       opcode,
   input  wire logic [31:0]      addr,
   input  wire logic [15:0]      length,
   output cmd_type               cmd,
   output logic [IDX_W-1:0]      first_idx
);

   localparam logic [63:0] CAP = 64'(SHADOW_ENTRIES) << GRANULE_SHIFT;

   logic [63:0]          eff64;
   logic [ADDR_BITS-1:0] lo, hi, b, e, len_a, endm1, chk_cnt;
   logic                 nonempty, in_win, outside, b_al, e_al, unset;

   always_comb begin
      eff64    = (64'(cfg.bytes) < CAP) ? 64'(cfg.bytes) : CAP;
      lo       = (ADDR_BITS)'(64'(cfg.base)) & ~(ADDR_BITS)'(7);
      hi       = lo + (ADDR_BITS)'(eff64);
      b        = (ADDR_BITS)'(64'(addr));
      len_a    = (ADDR_BITS)'(64'(length));
      e        = b + len_a;
      endm1    = e - (ADDR_BITS)'(1);
      nonempty = b < e;
      in_win   = nonempty && (b >= lo) && (e <= hi);
      outside  = nonempty && ((e <= lo) || (b >= hi));
      b_al     = (b[2:0] == 3'd0);
      e_al     = (e[2:0] == 3'd0);
      unset    = (lo == '0);
      chk_cnt  = (endm1 >> GRANULE_SHIFT) - (b >> GRANULE_SHIFT) + (ADDR_BITS)'(1);
      first_idx = IDX_W'(64'(b - lo) >> GRANULE_SHIFT);

      cmd         = '0;
      cmd.kind    = CMD_STATUS;
      cmd.status  = STS_OK;
      cmd.hi_off  = endm1[2:0];
      cmd.end_tag = e[2:0];
      unique case (opcode_type'(opcode))
         OP_CHECK: begin
            if (!cfg.enable || unset || length == 16'd0 || outside) begin
               cmd.status = STS_OK;
            end else if (!in_win) begin
               cmd.status = STS_EDGE;
            end else begin
               cmd.kind = CMD_CHECK;
               cmd.cnt  = CNT_W'(chk_cnt);
            end
         end
         OP_ACCESS: begin
            if (unset || length == 16'd0) begin
               cmd.status = STS_OK;
            end else if (!in_win || !b_al) begin
               cmd.status = STS_REJECT;
            end else begin
               cmd.kind   = CMD_FILL;
               cmd.cnt    = CNT_W'(length[15:3]);
               cmd.tag    = 8'd0;
               cmd.end_en = !e_al;
            end
         end
         OP_DATA, OP_HEAP: begin
            if (opcode_type'(opcode) == OP_HEAP && unset) begin
               cmd.status = STS_OK;
            end else if (!in_win || !b_al || !e_al) begin
               cmd.status = STS_REJECT;
            end else begin
               cmd.kind = CMD_FILL;
               cmd.cnt  = CNT_W'(length[15:3]);
               cmd.tag  = (opcode_type'(opcode) == OP_HEAP) ? cfg.heap_tag : cfg.data_tag;
            end
         end
         default: cmd.status = STS_OK;
      endcase
   end

endmodule
`default_nettype wire

@@ hdl/smac_queue.sv @@
`default_nettype none
module smac_queue
   import smac_pkg::*;
#(
   parameter int IDX_W = 12
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire cmd_type          push_cmd,
   input  wire logic [IDX_W-1:0] push_idx,
   input  wire logic             pop,
   output logic                  full,
   output logic                  empty,
   output cmd_type               head_cmd,
   output logic [IDX_W-1:0]      head_idx
);

   cmd_type          cmd_ff [2];
   logic [IDX_W-1:0] idx_ff [2];
   logic             wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]       count_ff, count_in;

   always_comb begin
      wp_in    = wp_ff ^ push;
      rp_in    = rp_ff ^ pop;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
      full     = (count_ff == 2'd2);
      empty    = (count_ff == 2'd0);
      head_cmd = cmd_ff[rp_ff];
      head_idx = idx_ff[rp_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= 1'b0;
         rp_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
         count_ff <= count_in;
      end
      if (push) begin
         cmd_ff[wp_ff] <= push_cmd;
         idx_ff[wp_ff] <= push_idx;
      end
   end

endmodule
`default_nettype wire

@@ hdl/smac_back.sv @@
`default_nettype none
module smac_back
   import smac_pkg::*;
#(
   parameter int SHADOW_ENTRIES = 4096,
   parameter int IDX_W          = 12
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             q_empty,
   input  wire cmd_type          q_cmd,
   input  wire logic [IDX_W-1:0] q_idx,
   output logic                  q_pop,
   output logic                  clearing,
   input  wire logic             rsp_pop,
   output logic                  rsp_empty,
   output logic [1:0]            rsp_status
);

   logic [7:0]       mem [SHADOW_ENTRIES];
   logic [7:0]       rdata_ff;
   state_type        state_ff, state_in;
   cmd_type          cmd_ff, cmd_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             fail_ff, fail_in;
   status_type       res_ff, res_in;
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff;
   logic             rsp_free, rsp_load, mem_we, bad, last;
   logic [7:0]       mem_wdata;
   logic [2:0]       hi;

   assign rsp_free   = !rsp_valid_ff || rsp_pop;
   assign rsp_empty  = !rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign last       = (cnt_ff == CNT_W'(1));

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:  if (idx_ff == IDX_W'(SHADOW_ENTRIES - 1)) state_in = ST_IDLE;
         ST_IDLE: begin
            if (!q_empty) begin
               unique case (q_cmd.kind)
                  CMD_CHECK: state_in = ST_CHK_RD;
                  CMD_FILL:  state_in = (q_cmd.cnt == '0) ? ST_ENDTAG : ST_FILL;
                  default:   state_in = ST_DONE;
               endcase
            end
         end
         ST_CHK_RD: state_in = ST_CHK_EV;
         ST_CHK_EV: state_in = last ? ST_DONE : ST_CHK_RD;
         ST_FILL: begin
            if (last) state_in = cmd_ff.end_en ? ST_ENDTAG : ST_DONE;
         end
         ST_ENDTAG: state_in = ST_DONE;
         ST_DONE:   if (rsp_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Outputs and datapath.
   always_comb begin
      q_pop     = 1'b0;
      mem_we    = 1'b0;
      mem_wdata = 8'd0;
      rsp_load  = 1'b0;
      cmd_in    = cmd_ff;
      idx_in    = idx_ff;
      cnt_in    = cnt_ff;
      fail_in   = fail_ff;
      res_in    = res_ff;
      clearing  = (state_ff == ST_CLEAR);
      hi        = last ? cmd_ff.hi_off : 3'd7;
      // A granule fails when it is a red zone or its valid prefix ends at or before hi.
      bad = (rdata_ff != 8'd0) &&
            (rdata_ff[7] || (rdata_ff[6:3] == 4'd0 && rdata_ff[2:0] <= hi));
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            idx_in = idx_ff + IDX_W'(1);
         end
         ST_IDLE: begin
            q_pop   = !q_empty;
            cmd_in  = q_cmd;
            idx_in  = q_idx;
            cnt_in  = q_cmd.cnt;
            fail_in = 1'b0;
            res_in  = q_cmd.status;
         end
         ST_CHK_EV: begin
            fail_in = fail_ff | bad;
            res_in  = (fail_ff | bad) ? STS_VIOL : STS_OK;
            idx_in  = idx_ff + IDX_W'(1);
            cnt_in  = cnt_ff - CNT_W'(1);
         end
         ST_FILL: begin
            mem_we    = 1'b1;
            mem_wdata = cmd_ff.tag;
            idx_in    = idx_ff + IDX_W'(1);
            cnt_in    = cnt_ff - CNT_W'(1);
         end
         ST_ENDTAG: begin
            mem_we    = 1'b1;
            mem_wdata = {5'd0, cmd_ff.end_tag};
         end
         ST_DONE:  rsp_load = rsp_free;
         default: ;
      endcase
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff  <= cmd_in;
      cnt_ff  <= cnt_in;
      fail_ff <= fail_in;
      res_ff  <= res_in;
      if (rsp_load) rsp_status_ff <= res_ff;
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[idx_ff] <= mem_wdata;
      rdata_ff <= mem[idx_ff];
   end

endmodule
`default_nettype wire
